// File: design/slid_pkg.sv
// Package for the sorted list block: sizes, request and status codes, sequencer states.
// No dependencies; used by sorted_list_insert_delete.
`default_nettype none
package slid_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int FILL_W   = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int OUT_W    = ((VAL_W + FILL_W + 7) / 8) * 8;

    // request codes (s_tuser)
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_DUMP   = 2'd2;

    // status codes (m_tuser)
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CHK,
        S_INS_PUT,
        S_DEL_RD,
        S_DEL_CHK,
        S_DMP_RD,
        S_DMP_OUT,
        S_RESP
    } state_t;

endpackage
`default_nettype wire

// File: design/sorted_list_insert_delete.sv
// Top level of the sorted list block: entry memory, the comparators on the read word and their sequencer.
// Depends on slid_pkg.
//
// Usage:
//   Input stream s_*: s_tuser carries the request (insert, delete, dump),
//   s_tdata the signed value. A word is taken when s_tvalid and s_tready are high.
//   Result stream m_*: m_tuser carries the status, m_tdata the item and the
//   fill count, m_tlast marks the final word of a request.
//   The block works on one request at a time; s_tready is high only while idle.
//   Insert walks the entries from the top with the >= comparator, moving each
//   larger-or-equal entry up one slot.
//   Delete walks the entries from the bottom, one read and one compare per
//   entry, closing the gap as it goes.
//   Dump reads one entry from the memory port per result word.
//   Full, not-found-on-empty and empty-dump cases go straight to the result.
//   The single memory read port makes every walk go one entry at a time.
//   Results go through an output register; while the receiver holds m_tready
//   low the sequencer waits at its next result, though a walk before it still changes the list.
//   Reset (aresetn low, synchronous) empties the list and drops any pending word;
//   no clearing pass is needed since only slots below the fill count are read.
`default_nettype none
module sorted_list_insert_delete (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [slid_pkg::VAL_W-1:0]  s_tdata,   // [31:0] value
    input  wire logic [1:0]                  s_tuser,   // [1:0] req_type
    // result stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [slid_pkg::OUT_W-1:0]       m_tdata,   // [31:0] item, [36:32] fill, rest 0
    output logic [1:0]                       m_tuser,   // [1:0] status
    output logic                             m_tlast
);

    localparam int IDX_W  = slid_pkg::IDX_W;
    localparam int FILL_W = slid_pkg::FILL_W;
    localparam int VAL_W  = slid_pkg::VAL_W;
    localparam int OUT_W  = slid_pkg::OUT_W;

    // entry memory
    logic signed [VAL_W-1:0] mem [slid_pkg::CAPACITY];
    logic signed [VAL_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [VAL_W-1:0] wr_data;

    // sequencer and datapath registers
    slid_pkg::state_t        state_reg, state_next;
    logic [FILL_W-1:0]       occ_reg, occ_next;
    logic [FILL_W-1:0]       idx_reg, idx_next;
    logic                    found_reg, found_next;
    logic signed [VAL_W-1:0] value_reg, value_next;
    logic [1:0]              status_reg, status_next;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]        m_item_reg, m_item_next;
    logic [FILL_W-1:0]       m_fill_reg, m_fill_next;
    logic [1:0]              m_status_reg, m_status_next;
    logic                    m_last_reg, m_last_next;

    logic                    in_fire;
    logic                    out_free;
    logic                    out_load;
    logic [1:0]              out_status;
    logic [VAL_W-1:0]        out_item;
    logic                    out_last;
    logic [FILL_W-1:0]       out_fill;
    logic [FILL_W-1:0]       occ_top;
    logic                    at_top;
    logic                    ge_hit;
    logic                    eq_hit;

    assign s_tready = (state_reg == slid_pkg::S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign occ_top  = occ_reg - 1'b1;
    assign at_top   = (idx_reg == occ_top);
    assign rd_addr  = idx_reg[IDX_W-1:0];

    // the comparators on the read word and the value
    assign ge_hit = (rd_data_reg >= value_reg);
    assign eq_hit = (rd_data_reg == value_reg);

    // memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            slid_pkg::S_IDLE: begin
                if (in_fire) begin
                    case (s_tuser)
                        slid_pkg::REQ_INSERT: begin
                            if (occ_reg == FILL_W'(slid_pkg::CAPACITY) || occ_reg == '0) begin
                                state_next = slid_pkg::S_RESP;
                            end else begin
                                state_next = slid_pkg::S_INS_RD;
                            end
                        end
                        slid_pkg::REQ_DELETE: begin
                            state_next = (occ_reg == '0) ? slid_pkg::S_RESP
                                                         : slid_pkg::S_DEL_RD;
                        end
                        slid_pkg::REQ_DUMP: begin
                            state_next = (occ_reg == '0) ? slid_pkg::S_RESP
                                                         : slid_pkg::S_DMP_RD;
                        end
                        default: state_next = slid_pkg::S_IDLE;
                    endcase
                end
            end
            slid_pkg::S_INS_RD:  state_next = slid_pkg::S_INS_CHK;
            slid_pkg::S_INS_CHK: begin
                if (!ge_hit) begin
                    state_next = slid_pkg::S_RESP;
                end else if (idx_reg == '0) begin
                    state_next = slid_pkg::S_INS_PUT;
                end else begin
                    state_next = slid_pkg::S_INS_RD;
                end
            end
            slid_pkg::S_INS_PUT: state_next = slid_pkg::S_RESP;
            slid_pkg::S_DEL_RD:  state_next = slid_pkg::S_DEL_CHK;
            slid_pkg::S_DEL_CHK: begin
                state_next = at_top ? slid_pkg::S_RESP : slid_pkg::S_DEL_RD;
            end
            slid_pkg::S_DMP_RD:  state_next = slid_pkg::S_DMP_OUT;
            slid_pkg::S_DMP_OUT: begin
                if (out_free) begin
                    state_next = at_top ? slid_pkg::S_IDLE : slid_pkg::S_DMP_RD;
                end
            end
            slid_pkg::S_RESP: begin
                if (out_free) begin
                    state_next = slid_pkg::S_IDLE;
                end
            end
            default: state_next = slid_pkg::S_IDLE;
        endcase
    end

    // datapath control and result words
    always_comb begin
        occ_next    = occ_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        value_next  = value_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg[IDX_W-1:0];
        wr_data     = value_reg;
        out_load    = 1'b0;
        out_status  = status_reg;
        out_item    = value_reg;
        out_last    = 1'b1;
        out_fill    = occ_reg;
        case (state_reg)
            slid_pkg::S_IDLE: begin
                if (in_fire) begin
                    value_next = s_tdata;
                    idx_next   = '0;
                    found_next = 1'b0;
                    case (s_tuser)
                        slid_pkg::REQ_INSERT: begin
                            if (occ_reg == FILL_W'(slid_pkg::CAPACITY)) begin
                                status_next = slid_pkg::ST_FULL;
                            end else if (occ_reg == '0) begin
                                // empty list: store straight into slot zero
                                wr_en       = 1'b1;
                                wr_addr     = '0;
                                wr_data     = s_tdata;
                                occ_next    = occ_reg + 1'b1;
                                status_next = slid_pkg::ST_OK;
                            end else begin
                                idx_next = occ_top;
                            end
                        end
                        slid_pkg::REQ_DELETE: begin
                            status_next = slid_pkg::ST_NOTFOUND;
                        end
                        slid_pkg::REQ_DUMP: begin
                            if (occ_reg == '0) begin
                                status_next = slid_pkg::ST_EMPTY;
                                value_next  = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // walk down from the top, moving entries not smaller than the value up
            slid_pkg::S_INS_CHK: begin
                wr_en   = 1'b1;
                wr_addr = IDX_W'(idx_reg + 1'b1);
                if (ge_hit) begin
                    wr_data  = rd_data_reg;
                    idx_next = idx_reg - 1'b1;
                    if (idx_reg == '0) begin
                        idx_next = '0;
                    end
                end else begin
                    wr_data     = value_reg;
                    occ_next    = occ_reg + 1'b1;
                    status_next = slid_pkg::ST_OK;
                end
            end
            slid_pkg::S_INS_PUT: begin
                wr_en       = 1'b1;
                wr_addr     = '0;
                wr_data     = value_reg;
                occ_next    = occ_reg + 1'b1;
                status_next = slid_pkg::ST_OK;
            end
            // walk up from the bottom; after the first match close the gap
            slid_pkg::S_DEL_CHK: begin
                if (found_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = IDX_W'(idx_reg - 1'b1);
                    wr_data = rd_data_reg;
                end else if (eq_hit) begin
                    found_next = 1'b1;
                end
                if (at_top) begin
                    if (found_reg || eq_hit) begin
                        occ_next    = occ_top;
                        status_next = slid_pkg::ST_OK;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            // one result word per stored entry
            slid_pkg::S_DMP_OUT: begin
                out_status = slid_pkg::ST_OK;
                out_item   = rd_data_reg;
                out_last   = at_top;
                if (out_free) begin
                    out_load = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            slid_pkg::S_RESP: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    // output register
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_item_next   = m_item_reg;
        m_fill_next   = m_fill_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        if (out_load) begin
            m_valid_next  = 1'b1;
            m_item_next   = out_item;
            m_fill_next   = out_fill;
            m_status_next = out_status;
            m_last_next   = out_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= slid_pkg::S_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        found_reg    <= found_next;
        value_reg    <= value_next;
        status_reg   <= status_next;
        m_item_reg   <= m_item_next;
        m_fill_reg   <= m_fill_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = OUT_W'({m_fill_reg, m_item_reg});

endmodule
`default_nettype wire
